[hdl/wps_pkg.sv]
// Shared types and constants for the wildcard pattern search block.
package wps_pkg;

   localparam int MAX_PATTERN_DEF   = 64;
   localparam int OFFSET_BITS_DEF   = 32;
   localparam int LEN_CSR_BITS      = 7;
   localparam int INDEX_BITS        = 6;
   localparam int BYTE_BITS         = 8;
   localparam int OFFSET_FIELD_BITS = 32;

   localparam logic KIND_PATTERN = 1'b0;
   localparam logic KIND_IMAGE   = 1'b1;

   typedef struct packed {
      logic                  wild;
      logic [BYTE_BITS-1:0]  value;
   } wps_entry_type;

   localparam wps_entry_type ENTRY_ANY = '{wild: 1'b1, value: 8'h00};

   typedef struct packed {
      logic                  kind;
      logic [INDEX_BITS-1:0] pattern_index;
      logic [BYTE_BITS-1:0]  pattern_value;
      logic                  pattern_wild;
      logic [BYTE_BITS-1:0]  image_byte;
      logic                  image_last;
   } wps_beat_type;

   typedef struct packed {
      logic                 exec_image;
      logic [BYTE_BITS-1:0] image_byte;
      logic                 image_last;
   } wps_ctl_type;

   typedef struct packed {
      logic                         valid;
      logic                         found;
      logic [OFFSET_FIELD_BITS-1:0] match_offset;
   } wps_result_type;

endpackage

[hdl/wps_pattern_store.sv]
// Pattern entry registers and alignment of the active entries to the window end.
module wps_pattern_store #(
   parameter int MAX_PATTERN = wps_pkg::MAX_PATTERN_DEF,
   parameter int IDX_BITS    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [wps_pkg::INDEX_BITS-1:0]    wr_index,
   input  wps_pkg::wps_entry_type            wr_entry,
   input  logic [IDX_BITS-1:0]               base,
   output wps_pkg::wps_entry_type            aligned [MAX_PATTERN]
);
   import wps_pkg::*;

   localparam int AW = (IDX_BITS > INDEX_BITS) ? IDX_BITS : INDEX_BITS;

   wps_entry_type pat_ff [MAX_PATTERN];
   wps_entry_type stg [IDX_BITS+1][MAX_PATTERN];

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (wr_en && (AW'(wr_index) == AW'(i))) begin
            pat_ff[i] <= wr_entry;
         end
      end
   end

   // shift entry i to window slot base+i; slots below base are don't-care
   always_comb begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
         stg[0][j] = pat_ff[j];
      end
      for (int s = 0; s < IDX_BITS; s++) begin
         for (int j = 0; j < MAX_PATTERN; j++) begin
            if (!base[s]) begin
               stg[s+1][j] = stg[s][j];
            end else if (j >= (1 << s)) begin
               stg[s+1][j] = stg[s][j - (1 << s)];
            end else begin
               stg[s+1][j] = ENTRY_ANY;
            end
         end
      end
      for (int j = 0; j < MAX_PATTERN; j++) begin
         aligned[j] = stg[IDX_BITS][j];
      end
   end

endmodule

[hdl/wps_window.sv]
// Sliding byte window, masked compare, byte count and search state.
module wps_window #(
   parameter int MAX_PATTERN = wps_pkg::MAX_PATTERN_DEF,
   parameter int OFFSET_BITS = wps_pkg::OFFSET_BITS_DEF,
   parameter int LEN_BITS    = $clog2(MAX_PATTERN + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  wps_pkg::wps_ctl_type    ctl,
   input  logic [LEN_BITS-1:0]     len,
   input  wps_pkg::wps_entry_type  aligned [MAX_PATTERN],
   output wps_pkg::wps_result_type res
);
   import wps_pkg::*;

   localparam int CMPW = (OFFSET_BITS > LEN_BITS) ? OFFSET_BITS : LEN_BITS;
   localparam int WB   = (OFFSET_BITS > OFFSET_FIELD_BITS) ? OFFSET_BITS : OFFSET_FIELD_BITS;

   logic [BYTE_BITS-1:0]   win_ff [MAX_PATTERN];
   logic [BYTE_BITS-1:0]   win_in [MAX_PATTERN];
   logic [OFFSET_BITS-1:0] seen_ff, seen_in, seen_next;
   logic                   done_ff, done_in;
   logic                   match, hit;
   logic [OFFSET_BITS-1:0] offset;
   logic [WB-1:0]          offset_wide;

   always_comb begin
      for (int j = 0; j < MAX_PATTERN - 1; j++) begin
         win_in[j] = win_ff[j+1];
      end
      win_in[MAX_PATTERN-1] = ctl.image_byte;
   end

   always_comb begin
      match = 1'b1;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         if (!aligned[j].wild && (aligned[j].value != win_in[j])) begin
            match = 1'b0;
         end
      end
   end

   assign seen_next   = (seen_ff == '1) ? seen_ff : seen_ff + 1'b1;
   assign hit         = (CMPW'(seen_next) >= CMPW'(len)) && match;
   assign offset      = seen_next - OFFSET_BITS'(len);
   assign offset_wide = WB'(offset);

   always_comb begin
      res       = '0;
      seen_in   = seen_ff;
      done_in   = done_ff;
      if (ctl.exec_image) begin
         if (!done_ff) begin
            seen_in = seen_next;
            if (hit) begin
               done_in          = 1'b1;
               res.valid        = 1'b1;
               res.found        = 1'b1;
               res.match_offset = offset_wide[OFFSET_FIELD_BITS-1:0];
            end else if (ctl.image_last) begin
               res.valid = 1'b1;
            end
         end
         if (ctl.image_last) begin
            seen_in = '0;
            done_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec_image && !done_ff) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         done_ff <= done_in;
      end
   end

`ifndef SYNTHESIS
   a_found_sets_done: assert property (@(posedge clock) disable iff (reset)
      res.valid && res.found && !ctl.image_last |=> done_ff)
      else $error("match reported but search not marked done");
   a_quiet_after_match: assert property (@(posedge clock) disable iff (reset)
      done_ff && ctl.exec_image |-> !res.valid)
      else $error("result given after a match");
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      ctl.exec_image && ctl.image_last |=> !done_ff && (seen_ff == '0))
      else $error("final byte did not restart the search");
`endif

endmodule

[hdl/wildcard_pattern_search_top.sv]
// Top level of the wildcard pattern search: beat registers, length register, handshake.
//
// Usage: write the window length through csr_wr_en / csr_wr_data while idle
// (0 acts as 1, values above MAX_PATTERN saturate). Load pattern entries with
// req_kind = 0 (index, byte, wildcard flag), then stream image bytes with
// req_kind = 1, marking the final byte with req_image_last.
// One rsp beat per image: found with the match offset for the first matching
// window, or not found when the final byte arrives without a match. Bytes
// after a match give no beat; the final byte restarts the search.
// A beat is captured in the input register, then evaluated, and its result
// is captured in the response register that drives rsp_*.
// Throughput: one beat per cycle while req_stall stays low; the masked compare of the full window is
// a single pass between the input register and the result register.
// Stall: with rsp_stall high and a result pending, the input register still
// takes one beat, then req_stall rises until the result is taken.
// Reset (synchronous): clears the beat valids, the byte count, the search
// state and sets the length to 1; pattern entries keep their contents.
module wildcard_pattern_search_top #(
   parameter int MAX_PATTERN = wps_pkg::MAX_PATTERN_DEF,
   parameter int OFFSET_BITS = wps_pkg::OFFSET_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [wps_pkg::LEN_CSR_BITS-1:0]       csr_wr_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_kind,
   input  logic [wps_pkg::INDEX_BITS-1:0]         req_pattern_index,
   input  logic [wps_pkg::BYTE_BITS-1:0]          req_pattern_value,
   input  logic                                   req_pattern_wild,
   input  logic [wps_pkg::BYTE_BITS-1:0]          req_image_byte,
   input  logic                                   req_image_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_found,
   output logic [wps_pkg::OFFSET_FIELD_BITS-1:0]  rsp_match_offset
);
   import wps_pkg::*;

   localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);
   localparam int IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int CW       = (LEN_BITS > LEN_CSR_BITS) ? LEN_BITS : LEN_CSR_BITS;

   logic [LEN_BITS-1:0]          len_ff, len_in;
   logic [CW-1:0]                csr_wide;
   logic                         a_valid_ff, a_valid_in;
   wps_beat_type                 a_beat_ff;
   logic                         out_free, req_take, exec;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff;
   logic [OFFSET_FIELD_BITS-1:0] rsp_offset_ff;
   logic [IDX_BITS-1:0]          base;
   wps_entry_type                wr_entry;
   wps_entry_type                aligned [MAX_PATTERN];
   wps_ctl_type                  ctl;
   wps_result_type               res;

   assign csr_wide = CW'(csr_wr_data);

   always_comb begin
      priority if (csr_wide == '0) begin
         len_in = LEN_BITS'(1);
      end else if (csr_wide > CW'(MAX_PATTERN)) begin
         len_in = LEN_BITS'(MAX_PATTERN);
      end else begin
         len_in = LEN_BITS'(csr_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_BITS'(1);
      end else if (csr_wr_en) begin
         len_ff <= len_in;
      end
   end

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign exec       = a_valid_ff && out_free;
   assign req_stall  = a_valid_ff && !out_free;
   assign req_take   = req_valid && !req_stall;
   assign a_valid_in = req_take || (a_valid_ff && !exec);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_beat_ff <= '{kind: req_kind, pattern_index: req_pattern_index,
                        pattern_value: req_pattern_value, pattern_wild: req_pattern_wild,
                        image_byte: req_image_byte, image_last: req_image_last};
      end
   end

   assign base     = IDX_BITS'(LEN_BITS'(MAX_PATTERN) - len_ff);
   assign wr_entry = '{wild: a_beat_ff.pattern_wild, value: a_beat_ff.pattern_value};

   assign ctl.exec_image = exec && (a_beat_ff.kind == KIND_IMAGE);
   assign ctl.image_byte = a_beat_ff.image_byte;
   assign ctl.image_last = a_beat_ff.image_last;

   wps_pattern_store #(
      .MAX_PATTERN (MAX_PATTERN),
      .IDX_BITS    (IDX_BITS)
   ) u_store (
      .clock    (clock),
      .wr_en    (exec && (a_beat_ff.kind == KIND_PATTERN)),
      .wr_index (a_beat_ff.pattern_index),
      .wr_entry (wr_entry),
      .base     (base),
      .aligned  (aligned)
   );

   wps_window #(
      .MAX_PATTERN (MAX_PATTERN),
      .OFFSET_BITS (OFFSET_BITS),
      .LEN_BITS    (LEN_BITS)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .len     (len_ff),
      .aligned (aligned),
      .res     (res)
   );

   assign rsp_valid_in = out_free ? (exec && res.valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec && res.valid) begin
         rsp_found_ff  <= res.found;
         rsp_offset_ff <= res.match_offset;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_offset_ff;

`ifndef SYNTHESIS
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      (len_ff != '0) && (CW'(len_ff) <= CW'(MAX_PATTERN)))
      else $error("window length out of range");
   a_held_beat: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !out_free |=> a_valid_ff && $stable(a_beat_ff))
      else $error("held input beat lost or changed");
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_offset == '0)
      else $error("not-found beat with nonzero offset");
`endif

endmodule
